// ===== rtl/core/jdsm_pkg.sv =====
// ----------------------------------------------------------------------------
// jdsm_pkg
// Shared types and constants of the joystick drive and servo mapper.
// ----------------------------------------------------------------------------
package jdsm_pkg;

	// one joystick report
	typedef struct packed {
		logic signed [15:0] fwd_stick;
		logic signed [15:0] strafe_stick;
		logic signed [15:0] yaw_stick;
		logic signed [15:0] tilt_stick;
		logic signed [15:0] pan_stick;
		logic               home_btn;
		logic               mast_down_btn;
		logic               mast_up_btn;
		logic               preset_prev_btn;
		logic               preset_next_btn;
		logic        [15:0] throttle;
	} in_item_t;

	// one drive and servo command
	typedef struct packed {
		logic signed [15:0] linear_x;
		logic signed [15:0] linear_y;
		logic signed [15:0] angular_z;
		logic signed [15:0] tilt_angle;
		logic signed [15:0] pan_angle;
		logic signed [15:0] mast_setpoint;
		logic        [7:0]  preset_index;
		logic               preset_request;
	} out_item_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_LIN_LIMIT     = 3'd0,
		REG_ANG_LIMIT     = 3'd1,
		REG_JOG_STEP      = 3'd2,
		REG_ANGLE_FLOOR   = 3'd3,
		REG_ANGLE_CEILING = 3'd4,
		REG_DEAD_BAND     = 3'd5,
		REG_HOME_PAN      = 3'd6,
		REG_HOME_TILT     = 3'd7
	} reg_index_t;

	// configuration register contents
	typedef struct packed {
		logic        [15:0] lin_limit;
		logic        [15:0] ang_limit;
		logic        [11:0] jog_step;
		logic signed [15:0] angle_floor;
		logic signed [15:0] angle_ceiling;
		logic        [14:0] dead_band;
		logic signed [15:0] home_pan;
		logic signed [15:0] home_tilt;
	} cfg_t;

	localparam logic        [15:0] RST_LIN_LIMIT     = 16'd256;
	localparam logic        [15:0] RST_ANG_LIMIT     = 16'd256;
	localparam logic        [11:0] RST_JOG_STEP      = 12'd41;
	localparam logic signed [15:0] RST_ANGLE_FLOOR   = -16'sd12861;
	localparam logic signed [15:0] RST_ANGLE_CEILING = 16'sd12861;
	localparam logic        [14:0] RST_DEAD_BAND     = 15'd328;
	localparam logic signed [15:0] RST_HOME_PAN      = 16'sd0;
	localparam logic signed [15:0] RST_HOME_TILT     = 16'sd0;

	// velocity axes
	typedef enum logic [1:0] {
		AXIS_FWD    = 2'd0,
		AXIS_STRAFE = 2'd1,
		AXIS_YAW    = 2'd2
	} axis_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_ARM  = 2'd1,
		ST_CALC = 2'd2,
		ST_FIN  = 2'd3
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic  load;
		logic  arm_check;
		logic  a_en;
		axis_t a_sel;
		logic  b_en;
		logic  r_en;
		axis_t r_sel;
		logic  fin;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic armed;
		logic out_busy;
	} dp_status_t;

endpackage

// ===== rtl/core/jdsm_cfg.sv =====
// ----------------------------------------------------------------------------
// jdsm_cfg
// Configuration register file, written one register per handshake.
// ----------------------------------------------------------------------------
module jdsm_cfg
	import jdsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg        = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lin_limit     <= RST_LIN_LIMIT;
			cfg_q.ang_limit     <= RST_ANG_LIMIT;
			cfg_q.jog_step      <= RST_JOG_STEP;
			cfg_q.angle_floor   <= RST_ANGLE_FLOOR;
			cfg_q.angle_ceiling <= RST_ANGLE_CEILING;
			cfg_q.dead_band     <= RST_DEAD_BAND;
			cfg_q.home_pan      <= RST_HOME_PAN;
			cfg_q.home_tilt     <= RST_HOME_TILT;
		end else if (cfg_valid) begin
			unique case (reg_index_t'(cfg_index))
				REG_LIN_LIMIT:     cfg_q.lin_limit     <= cfg_data;
				REG_ANG_LIMIT:     cfg_q.ang_limit     <= cfg_data;
				REG_JOG_STEP:      cfg_q.jog_step      <= cfg_data[11:0];
				REG_ANGLE_FLOOR:   cfg_q.angle_floor   <= cfg_data;
				REG_ANGLE_CEILING: cfg_q.angle_ceiling <= cfg_data;
				REG_DEAD_BAND:     cfg_q.dead_band     <= cfg_data[14:0];
				REG_HOME_PAN:      cfg_q.home_pan      <= cfg_data;
				REG_HOME_TILT:     cfg_q.home_tilt     <= cfg_data;
				default:           cfg_q.lin_limit     <= cfg_q.lin_limit;
			endcase
		end
	end

endmodule

// ===== rtl/core/jdsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// jdsm_ctrl
// Sequencer: accepts an item, then arms, or runs the velocity steps and retires.
// ----------------------------------------------------------------------------
module jdsm_ctrl
	import jdsm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	// last step of the velocity sequence
	localparam logic [2:0] CNT_LAST = 3'd4;

	state_t     state_q, state_d;
	logic [2:0] cnt_q;
	logic [1:0] r_idx;

	assign r_idx = cnt_q[1:0] - 2'd2;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// step counter within the velocity sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_CALC) begin
			cnt_q <= cnt_q + 3'd1;
		end else begin
			cnt_q <= '0;
		end
	end

	// next state and commands
	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.a_sel     = AXIS_FWD;
		cmd.r_sel     = AXIS_FWD;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = status.armed ? ST_CALC : ST_ARM;
				end
			end
			ST_ARM: begin
				cmd.arm_check = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_CALC: begin
				// three axes flow through multiply, multiply, round
				cmd.a_en  = (cnt_q < 3'd3);
				cmd.a_sel = axis_t'(cnt_q[1:0]);
				cmd.b_en  = (cnt_q >= 3'd1) && (cnt_q <= 3'd3);
				cmd.r_en  = (cnt_q >= 3'd2);
				cmd.r_sel = axis_t'(r_idx);
				if (cnt_q == CNT_LAST) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!status.out_busy) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/core/jdsm_dp.sv =====
// ----------------------------------------------------------------------------
// jdsm_dp
// Datapath: input capture, shared velocity multipliers, servo and preset
// state, and the output register.
// ----------------------------------------------------------------------------
module jdsm_dp
	import jdsm_pkg::*;
#(
	parameter int NUM_PRESETS = 8
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   in_data,
	input  cfg_t       cfg,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data
);

	localparam int         PW      = (NUM_PRESETS > 1) ? $clog2(NUM_PRESETS) : 1;
	localparam logic [8:0] NP      = 9'(NUM_PRESETS);
	localparam logic [8:0] NP_LAST = 9'(NUM_PRESETS - 1);

	in_item_t           in_q;
	logic               armed_q;
	logic               latch_q;
	logic [PW-1:0]      preset_q;
	logic signed [15:0] tilt_q, pan_q, mast_q;
	logic signed [15:0] vel_q [3];
	logic               out_valid_q;
	out_item_t          out_q;

	// velocity pipeline
	logic [31:0]        a_s1;
	logic               neg_s1;
	logic [47:0]        b_s2;
	logic               neg_s2;

	assign status.armed    = armed_q;
	assign status.out_busy = out_valid_q && !out_ready;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

	// magnitude below the deadzone
	function automatic logic inside_db(input logic signed [15:0] v, input logic [14:0] db);
		logic [15:0] m;
		m = v[15] ? 16'(-v) : 16'(v);
		return m < {1'b0, db};
	endfunction

	// jog by one step in either direction, then clamp to floor and ceiling
	function automatic logic signed [15:0] jog_clamp(
		input logic signed [15:0] base,
		input logic               dec,
		input logic               inc,
		input logic        [11:0] step,
		input logic signed [15:0] lo,
		input logic signed [15:0] hi
	);
		logic signed [17:0] a;
		a = 18'(base);
		if (dec) begin
			a = a - $signed({6'd0, step});
		end else if (inc) begin
			a = a + $signed({6'd0, step});
		end
		if (a < 18'(lo)) begin
			a = 18'(lo);
		end
		if (a > 18'(hi)) begin
			a = 18'(hi);
		end
		return a[15:0];
	endfunction

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= in_data;
		end
	end

	// first multiply: stick magnitude times limit
	logic signed [15:0] a_stick;
	logic        [15:0] a_limit;
	logic        [15:0] a_mag;
	always_comb begin
		case (cmd.a_sel)
			AXIS_STRAFE: begin
				a_stick = in_q.strafe_stick;
				a_limit = cfg.lin_limit;
			end
			AXIS_YAW: begin
				a_stick = in_q.yaw_stick;
				a_limit = cfg.ang_limit;
			end
			default: begin
				a_stick = in_q.fwd_stick;
				a_limit = cfg.lin_limit;
			end
		endcase
		a_mag = a_stick[15] ? 16'(-a_stick) : 16'(a_stick);
	end

	always_ff @(posedge clk) begin
		if (cmd.a_en) begin
			a_s1   <= a_mag * a_limit;
			neg_s1 <= a_stick[15];
		end
	end

	// second multiply: times the clamped throttle
	logic [15:0] thr;
	assign thr = (in_q.throttle > 16'd32768) ? 16'd32768 : in_q.throttle;

	always_ff @(posedge clk) begin
		if (cmd.b_en) begin
			b_s2   <= 48'(a_s1) * 48'(thr);
			neg_s2 <= neg_s1;
		end
	end

	// round to nearest, ties away from zero, and saturate
	logic [47:0]        rnd_sum;
	logic [17:0]        rnd;
	logic signed [15:0] vel_sat;
	always_comb begin
		rnd_sum = b_s2 + 48'h0000_2000_0000;
		rnd     = rnd_sum[47:30];
		if (neg_s2) begin
			vel_sat = (rnd > 18'd32768) ? -16'sd32768 : 16'(-rnd);
		end else begin
			vel_sat = (rnd > 18'd32767) ? 16'sd32767 : 16'(rnd);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.r_en) begin
			vel_q[cmd.r_sel] <= vel_sat;
		end
	end

	// preset stepping
	logic          latch_d;
	logic [PW-1:0] preset_d;
	logic          request;
	logic [8:0]    pos;
	always_comb begin
		latch_d  = latch_q;
		preset_d = preset_q;
		request  = 1'b0;
		pos      = 9'(preset_q);
		if (!in_q.preset_prev_btn && !in_q.preset_next_btn) begin
			latch_d = 1'b0;
		end else if (!latch_q) begin
			latch_d = 1'b1;
			request = 1'b1;
			if (pos >= NP) begin
				pos = NP_LAST;
			end
			if (in_q.preset_prev_btn) begin
				pos = (pos == 9'd0) ? NP_LAST : pos - 9'd1;
			end
			if (in_q.preset_next_btn) begin
				pos = (pos + 9'd1 >= NP) ? 9'd0 : pos + 9'd1;
			end
			preset_d = pos[PW-1:0];
		end
	end

	// servo jogging
	logic signed [15:0] tilt_d, pan_d, mast_d;
	logic signed [15:0] tilt_base, pan_base;
	logic signed [16:0] ndb;
	always_comb begin
		ndb       = -$signed({2'b00, cfg.dead_band});
		tilt_base = in_q.home_btn ? cfg.home_tilt : tilt_q;
		pan_base  = in_q.home_btn ? cfg.home_pan : pan_q;
		tilt_d    = jog_clamp(tilt_base,
			17'(in_q.tilt_stick) > $signed({2'b00, cfg.dead_band}),
			17'(in_q.tilt_stick) < ndb,
			cfg.jog_step, cfg.angle_floor, cfg.angle_ceiling);
		pan_d     = jog_clamp(pan_base,
			17'(in_q.pan_stick) < ndb,
			17'(in_q.pan_stick) > $signed({2'b00, cfg.dead_band}),
			cfg.jog_step, cfg.angle_floor, cfg.angle_ceiling);
		mast_d    = jog_clamp(mast_q, in_q.mast_down_btn, in_q.mast_up_btn,
			cfg.jog_step, cfg.angle_floor, cfg.angle_ceiling);
	end

	// control state: arming, preset and servo positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q  <= 1'b0;
			latch_q  <= 1'b0;
			preset_q <= '0;
			tilt_q   <= RST_HOME_TILT;
			pan_q    <= RST_HOME_PAN;
			mast_q   <= '0;
		end else begin
			if (cmd.arm_check && inside_db(in_q.fwd_stick, cfg.dead_band)
					&& inside_db(in_q.strafe_stick, cfg.dead_band)
					&& inside_db(in_q.yaw_stick, cfg.dead_band)) begin
				armed_q <= 1'b1;
			end
			if (cmd.fin) begin
				latch_q  <= latch_d;
				preset_q <= preset_d;
				tilt_q   <= tilt_d;
				pan_q    <= pan_d;
				mast_q   <= mast_d;
			end
		end
	end

	// output item valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output item payload
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_q.linear_x       <= vel_q[AXIS_FWD];
			out_q.linear_y       <= vel_q[AXIS_STRAFE];
			out_q.angular_z      <= vel_q[AXIS_YAW];
			out_q.tilt_angle     <= tilt_d;
			out_q.pan_angle      <= pan_d;
			out_q.mast_setpoint  <= mast_d;
			out_q.preset_index   <= 8'(preset_d);
			out_q.preset_request <= request;
		end
	end

endmodule

// ===== rtl/core/joystick_drive_servo_mapper_top.sv =====
// ----------------------------------------------------------------------------
// joystick_drive_servo_mapper_top
// Maps joystick reports to drive velocities, servo angles and a preset index.
// ----------------------------------------------------------------------------
//
//  channel  signals                         carries
//  -------  ------------------------------  ------------------------------
//  in       in_valid, in_ready, in_data     one joystick report
//  out      out_valid, out_ready, out_data  one drive and servo command
//  cfg      cfg_valid, cfg_ready,           one register write
//           cfg_index, cfg_data
//
//  an armed report passes accept, five steps in which the three axes
//  pass a 16x16 and a 32x16 multiplier pair and a rounding stage, and retire
//  a report before arming passes accept and an arm check and gives no item
//  asynchronous reset, no clearing pass; cfg writes complete every cycle
//  retire waits while the previous item is still held in the output register
//
module joystick_drive_servo_mapper_top
	import jdsm_pkg::*;
#(
	parameter int NUM_PRESETS = 8
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;

	// configuration registers
	jdsm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer
	jdsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath
	jdsm_dp #(
		.NUM_PRESETS (NUM_PRESETS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg       (cfg),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
